// ===== rtl/core/wavelength_to_rgb_defines.svh =====
// Assertion macros used by the checker file.
`ifndef WAVELENGTH_TO_RGB_DEFINES_SVH
`define WAVELENGTH_TO_RGB_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define WTR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define WTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wtr_pkg.sv =====
package wtr_pkg;

	localparam int GAMMA_HUNDREDTHS  = 80;
	localparam int FRACTION_BITS     = 12;
	localparam int FRACTION_BITS_MAX = 16;
	localparam int P_MAX_W           = FRACTION_BITS_MAX + 1;

	localparam int WAVE_W      = 10;
	localparam int INTENSITY_W = 8;
	localparam int CHAN_W      = 8;
	localparam int GAMMA_W     = 12;
	localparam int ROM_FULL    = 4095;
	localparam int NUM_CHAN    = 3;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	localparam logic [INTENSITY_W-1:0] INTENSITY_RESET = 8'd255;

	// Scaled level t = intensity * gamma; the output is floor((t + 2047) / 4095),
	// done as a multiply by a ceiling reciprocal. It is exact for t + 2047 < 2^20.
	localparam int PROD_W      = GAMMA_W + INTENSITY_W;
	localparam int RECIP_SHIFT = 33;
	localparam int RECIP_W     = 22;
	localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + ROM_FULL - 1) / ROM_FULL;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(ROM_FULL / 2);
	localparam int WIDE_W = PROD_W + RECIP_W;

	typedef struct packed {
		logic               alpha;
		logic [P_MAX_W-1:0] pb;
		logic [P_MAX_W-1:0] pg;
		logic [P_MAX_W-1:0] pr;
	} color_entry_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Half-up rounding of num * 2^fb / den, found bit by bit from the top.
	function automatic logic [P_MAX_W-1:0] round_ratio(longint num, longint den, int fb);
		longint rhs;
		longint p;
		longint trial;
		int b;
		rhs = 2 * num * (longint'(1) << fb) + den;
		p = 0;
		for (b = P_MAX_W - 1; b >= 0; b--) begin
			trial = p | (longint'(1) << b);
			if (trial * 2 * den <= rhs) begin
				p = trial;
			end
		end
		return P_MAX_W'(p);
	endfunction

	// Hue ramps times edge attenuation for one wavelength, as ramp fractions.
	function automatic color_entry_t color_entry(int w, int fb);
		int rn, rd, gn, gd, bn, bd, an, ad;
		color_entry_t e;
		rn = 0; rd = 1; gn = 0; gd = 1; bn = 0; bd = 1; an = 0; ad = 1;
		if (w >= 380 && w < 440) begin
			rn = 440 - w; rd = 60; bn = 1;
		end else if (w >= 440 && w < 490) begin
			gn = w - 440; gd = 50; bn = 1;
		end else if (w >= 490 && w < 510) begin
			gn = 1; bn = 510 - w; bd = 20;
		end else if (w >= 510 && w < 580) begin
			rn = w - 510; rd = 70; gn = 1;
		end else if (w >= 580 && w < 645) begin
			rn = 1; gn = 645 - w; gd = 65;
		end else if (w >= 645 && w <= 780) begin
			rn = 1;
		end
		if (w >= 380 && w < 420) begin
			an = 120 + 7 * (w - 380); ad = 400;
		end else if (w >= 420 && w < 701) begin
			an = 1; ad = 1;
		end else if (w >= 701 && w < 780) begin
			an = 240 + 7 * (780 - w); ad = 800;
		end
		e.pr = round_ratio(longint'(rn * an), longint'(rd * ad), fb);
		e.pg = round_ratio(longint'(gn * an), longint'(gd * ad), fb);
		e.pb = round_ratio(longint'(bn * an), longint'(bd * ad), fb);
		e.alpha = (an == ad);
		return e;
	endfunction

	// Gamma table entry: round(4095 * (q / 2^fb)^gamma).
	function automatic logic [GAMMA_W-1:0] gamma_value(int q, int fb);
		real x;
		real y;
		int r;
		if (q == 0) begin
			return '0;
		end
		x = real'(q) * (2.0 ** (-real'(fb)));
		y = real'(ROM_FULL) * (x ** (real'(GAMMA_HUNDREDTHS) / 100.0));
		r = $rtoi(y + 0.5);
		if (r > ROM_FULL) begin
			r = ROM_FULL;
		end
		return GAMMA_W'(r);
	endfunction

endpackage

// ===== rtl/core/wtr_color_rom.sv =====
module wtr_color_rom #(
	parameter int FRACTION_BITS = wtr_pkg::FRACTION_BITS
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [wtr_pkg::WAVE_W-1:0]     wavelength,
	output logic [FRACTION_BITS:0]         p_s1 [wtr_pkg::NUM_CHAN],
	output logic                           alpha_s1
);

	localparam int DEPTH = 2 ** wtr_pkg::WAVE_W;

	wtr_pkg::color_entry_t rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom[i] = wtr_pkg::color_entry(i, FRACTION_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0]  <= rom[wavelength].pr[FRACTION_BITS:0];
			p_s1[1]  <= rom[wavelength].pg[FRACTION_BITS:0];
			p_s1[2]  <= rom[wavelength].pb[FRACTION_BITS:0];
			alpha_s1 <= rom[wavelength].alpha;
		end
	end

endmodule

// ===== rtl/core/wtr_gamma_rom.sv =====
module wtr_gamma_rom #(
	parameter int FRACTION_BITS = wtr_pkg::FRACTION_BITS
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [FRACTION_BITS:0]       p,
	output logic [wtr_pkg::GAMMA_W-1:0]  level_s2
);

	localparam int DEPTH = 2 ** FRACTION_BITS + 1;

	logic [wtr_pkg::GAMMA_W-1:0] rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom[i] = wtr_pkg::gamma_value(i, FRACTION_BITS);
	end

	// The ramp fractions never exceed 1.0, so p stays within the table.
	always_ff @(posedge clk) begin
		if (en) begin
			level_s2 <= rom[p];
		end
	end

endmodule

// ===== rtl/core/wtr_scale.sv =====
module wtr_scale (
	input  logic                             clk,
	input  wtr_pkg::stage_en_t               en,
	input  logic [wtr_pkg::INTENSITY_W-1:0]  intensity,
	input  logic [wtr_pkg::GAMMA_W-1:0]      level,
	output logic [wtr_pkg::CHAN_W-1:0]       chan_s4
);

	logic [wtr_pkg::PROD_W-1:0] scaled_s3;
	logic [wtr_pkg::PROD_W-1:0] biased;
	logic [wtr_pkg::WIDE_W-1:0] wide;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			scaled_s3 <= wtr_pkg::PROD_W'(intensity) * wtr_pkg::PROD_W'(level);
		end
	end

	// Half-up division by 4095 through the reciprocal; no correction step is needed.
	assign biased = scaled_s3 + wtr_pkg::ROUND_BIAS;
	assign wide   = wtr_pkg::WIDE_W'(biased) * wtr_pkg::WIDE_W'(wtr_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			chan_s4 <= wide[wtr_pkg::RECIP_SHIFT +: wtr_pkg::CHAN_W];
		end
	end

endmodule

// ===== rtl/core/wavelength_to_rgb.sv =====
// Channel  Handshake               Data            Fields, lowest bit first
// s_*      s_tvalid / s_tready     s_tdata[15:0]   [9:0] wavelength_nm
// m_*      m_tvalid / m_tready     m_tdata[31:0]   [7:0] red, [15:8] green, [23:16] blue,
//                                                  [24] alpha_full
// cfg_*    cfg_valid / cfg_ready   cfg_data[7:0]   intensity_max
//
// One wavelength per cycle while m_tready does not stall the output; each color is
// registered in each of the stages below in turn before it is on m_tdata.
// The four stages are the ramp table, the gamma table, the intensity multiply and
// the reciprocal multiply that divides by 4095.
// Reset clears the stage valid bits and loads intensity_max with 255; cfg_ready is
// always high. A stall on m_tready holds the result, and earlier stages keep closing
// bubbles, so s_tready drops only when all four stages hold a color.
module wavelength_to_rgb #(
	parameter int FRACTION_BITS = wtr_pkg::FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wtr_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] wavelength_nm
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wtr_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] red, [15:8] green,
	                                                     // [23:16] blue, [24] alpha_full
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wtr_pkg::INTENSITY_W-1:0]   cfg_data   // intensity_max
);

	localparam int PAD_W = wtr_pkg::M_TDATA_W - 3 * wtr_pkg::CHAN_W - 1;

	wtr_pkg::stage_en_t en;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic [wtr_pkg::INTENSITY_W-1:0] intensity_q;

	logic [FRACTION_BITS:0]        p_s1     [wtr_pkg::NUM_CHAN];
	logic [wtr_pkg::GAMMA_W-1:0]   level_s2 [wtr_pkg::NUM_CHAN];
	logic [wtr_pkg::CHAN_W-1:0]    chan_s4  [wtr_pkg::NUM_CHAN];

	// A stage may load when it is empty or when the stage after it loads.
	assign en.s4 = !valid_s4 || m_tready;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign s_tready  = en.s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= wtr_pkg::INTENSITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			intensity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) alpha_s2 <= alpha_s1;
		if (en.s3) alpha_s3 <= alpha_s2;
		if (en.s4) alpha_s4 <= alpha_s3;
	end

	wtr_color_rom #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_color_rom (
		.clk        (clk),
		.en         (en.s1),
		.wavelength (s_tdata[wtr_pkg::WAVE_W-1:0]),
		.p_s1       (p_s1),
		.alpha_s1   (alpha_s1)
	);

	for (genvar c = 0; c < wtr_pkg::NUM_CHAN; c++) begin : g_chan
		wtr_gamma_rom #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_gamma_rom (
			.clk      (clk),
			.en       (en.s2),
			.p        (p_s1[c]),
			.level_s2 (level_s2[c])
		);

		wtr_scale u_scale (
			.clk       (clk),
			.en        (en),
			.intensity (intensity_q),
			.level     (level_s2[c]),
			.chan_s4   (chan_s4[c])
		);
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {{PAD_W{1'b0}}, alpha_s4, chan_s4[2], chan_s4[1], chan_s4[0]};

endmodule

// ===== rtl/core/wtr_checker.sv =====
`include "wavelength_to_rgb_defines.svh"

module wtr_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tready,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [wtr_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [wtr_pkg::INTENSITY_W-1:0]  cfg_data
);

	logic [wtr_pkg::INTENSITY_W-1:0] intensity_q;
	logic [wtr_pkg::CHAN_W-1:0] red, green, blue;
	logic alpha;
	logic out_stall, in_bound, has_peak;

	// Shadow of the intensity register, seen from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= wtr_pkg::INTENSITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			intensity_q <= cfg_data;
		end
	end

	assign red   = m_tdata[0 +: wtr_pkg::CHAN_W];
	assign green = m_tdata[wtr_pkg::CHAN_W +: wtr_pkg::CHAN_W];
	assign blue  = m_tdata[2 * wtr_pkg::CHAN_W +: wtr_pkg::CHAN_W];
	assign alpha = m_tdata[3 * wtr_pkg::CHAN_W];

	assign out_stall = m_tvalid && !m_tready;
	assign in_bound  = (red <= intensity_q) && (green <= intensity_q) && (blue <= intensity_q);
	assign has_peak  = (red == intensity_q) || (green == intensity_q) || (blue == intensity_q);

	`WTR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled color changed")

	`WTR_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready, "input refused with an empty output")

	`WTR_ASSERT_IMPL(a_chan_bound, m_tvalid, in_bound, "channel above intensity_max")

	`WTR_ASSERT_IMPL(a_full_has_peak, m_tvalid && alpha, has_peak, "full alpha without a peak")

endmodule

bind wavelength_to_rgb wtr_checker u_wtr_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int ONE_Q      = 1 << wtr_pkg::FRACTION_BITS;
	localparam int ROM_FULL   = wtr_pkg::ROM_FULL;
	localparam int BIG_W      = 160;
	localparam int NUM_PHASES = 6;
	localparam int RAND_ITEMS = 135;

	typedef logic [wtr_pkg::WAVE_W-1:0]      wave_t;
	typedef logic [wtr_pkg::INTENSITY_W-1:0] level_t;
	typedef logic [wtr_pkg::CHAN_W-1:0]      chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  alpha_full;
	} color_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [wtr_pkg::S_TDATA_W-1:0]  s_tdata;   // [9:0] wavelength_nm
	logic                           m_tvalid;
	logic                           m_tready;
	logic [wtr_pkg::M_TDATA_W-1:0]  m_tdata;   // [7:0] red, [15:8] green,
	                                           // [23:16] blue, [24] alpha_full
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [wtr_pkg::INTENSITY_W-1:0] cfg_data; // intensity_max

	logic [wtr_pkg::GAMMA_W-1:0] gamma_tbl [0:ONE_Q];
	wave_t  wave_backlog [$];
	color_t expected_colors [$];
	level_t shade_level = 8'd255;
	logic   s_fire = 1'b0;
	logic   steady = 1'b0;
	int     gap_left = 0;
	int     stall_left = 0;
	int     mismatch_count = 0;

	wavelength_to_rgb u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Entry q is the largest y with (2y-1)^a * 2^(fb*b) <= 8190^a * q^b, where the
	// gamma is b/a in lowest terms. This is half-up rounding of 4095 * x^gamma.
	function automatic void build_gamma_table();
		int g, h, t, pa, pb, i, q;
		int unsigned y;
		logic stop;
		logic [BIG_W-1:0] base, rhs, lhs;
		g = wtr_pkg::GAMMA_HUNDREDTHS;
		h = 100;
		while (g != 0) begin
			t = h % g;
			h = g;
			g = t;
		end
		pa = 100 / h;
		pb = wtr_pkg::GAMMA_HUNDREDTHS / h;
		base = 1;
		for (i = 0; i < pa; i++) begin
			base = base * BIG_W'(2 * ROM_FULL);
		end
		y = 0;
		for (q = 0; q <= ONE_Q; q++) begin
			rhs = base;
			for (i = 0; i < pb; i++) begin
				rhs = rhs * BIG_W'(q);
			end
			stop = 1'b0;
			while (y < ROM_FULL && !stop) begin
				lhs = 1;
				for (i = 0; i < pa; i++) begin
					lhs = lhs * BIG_W'(2 * y + 1);
				end
				lhs = lhs << (wtr_pkg::FRACTION_BITS * pb);
				if (lhs <= rhs) begin
					y++;
				end else begin
					stop = 1'b1;
				end
			end
			gamma_tbl[q] = wtr_pkg::GAMMA_W'(y);
		end
	endfunction

	// One channel: ramp cn/cd times attenuation an/ad, rounded to the table
	// index, through the gamma table, then scaled by the intensity with rounding.
	function automatic chan_t shade_channel(int cn, int cd, int an, int ad, level_t level);
		longint unsigned den, p, v;
		den = longint'(cd) * longint'(ad);
		p = (2 * longint'(cn) * longint'(an) * ONE_Q + den) / (2 * den);
		if (p > ONE_Q) begin
			p = ONE_Q;
		end
		v = gamma_tbl[p];
		return chan_t'((2 * longint'(level) * v + ROM_FULL) / (2 * ROM_FULL));
	endfunction

	function automatic color_t predict_color(wave_t wave, level_t level);
		int w, rn, rd, gn, gd, bn, bd, an, ad;
		color_t c;
		w = int'(wave);
		rn = 0; rd = 1; gn = 0; gd = 1; bn = 0; bd = 1; an = 0; ad = 1;
		if (w >= 380 && w < 440) begin
			rn = 440 - w; rd = 60; bn = 1;
		end else if (w >= 440 && w < 490) begin
			gn = w - 440; gd = 50; bn = 1;
		end else if (w >= 490 && w < 510) begin
			gn = 1; bn = 510 - w; bd = 20;
		end else if (w >= 510 && w < 580) begin
			rn = w - 510; rd = 70; gn = 1;
		end else if (w >= 580 && w < 645) begin
			rn = 1; gn = 645 - w; gd = 65;
		end else if (w >= 645 && w <= 780) begin
			rn = 1;
		end
		if (w >= 380 && w < 420) begin
			an = 120 + 7 * (w - 380); ad = 400;
		end else if (w >= 420 && w < 701) begin
			an = 1; ad = 1;
		end else if (w >= 701 && w < 780) begin
			an = 240 + 7 * (780 - w); ad = 800;
		end
		c.red        = shade_channel(rn, rd, an, ad, level);
		c.green      = shade_channel(gn, gd, an, ad, level);
		c.blue       = shade_channel(bn, bd, an, ad, level);
		c.alpha_full = (an == ad);
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Wavelength driver. s_fire tells whether the item on the bus was taken at
	// the last rising edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left = 0;
		end else if (s_tvalid && !s_fire) begin
			s_tvalid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			gap_left = $urandom_range(0, 7);
			s_tvalid <= 1'b0;
		end else if (wave_backlog.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= wtr_pkg::S_TDATA_W'(wave_backlog.pop_front());
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Color sink with random back-pressure, always ready in the steady phase.
	always @(negedge clk) begin
		if (!arst_n || steady) begin
			m_tready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		color_t want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_colors.push_back(predict_color(s_tdata[wtr_pkg::WAVE_W-1:0],
					shade_level));
			end
			if (m_tvalid && m_tready) begin
				if (expected_colors.size() == 0) begin
					$error("color transaction 0x%08h with none expected", m_tdata);
					mismatch_count++;
				end else begin
					want = expected_colors.pop_front();
					if (m_tdata[7:0] !== want.red) begin
						$error("red expected %0d actual %0d", want.red, m_tdata[7:0]);
						mismatch_count++;
					end
					if (m_tdata[15:8] !== want.green) begin
						$error("green expected %0d actual %0d", want.green, m_tdata[15:8]);
						mismatch_count++;
					end
					if (m_tdata[23:16] !== want.blue) begin
						$error("blue expected %0d actual %0d", want.blue, m_tdata[23:16]);
						mismatch_count++;
					end
					if (m_tdata[24] !== want.alpha_full) begin
						$error("alpha_full expected %0d actual %0d", want.alpha_full,
							m_tdata[24]);
						mismatch_count++;
					end
				end
			end
		end
	end

	task automatic write_level(input level_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		shade_level = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every wavelength has been taken and every color has arrived,
	// then lets the pipeline settle.
	task automatic wait_drained();
		while (wave_backlog.size() != 0 || s_tvalid || expected_colors.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int ph, n;
		int unsigned edges [$];
		level_t plan [NUM_PHASES];
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		build_gamma_table();
		// Ramp and attenuation boundaries, out-of-range values and all-ones input.
		edges = '{0, 379, 380, 381, 419, 420, 439, 440, 489, 490, 509, 510, 579,
			580, 644, 645, 700, 701, 779, 780, 781, 1023, 555, 512};
		plan = '{8'd255, 8'd0, 8'd1, 8'd170, level_t'($urandom_range(0, 255)), 8'd255};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			write_level(plan[ph]);
			@(posedge clk);
			steady = (ph == NUM_PHASES - 1);
			foreach (edges[k]) begin
				if (ph == 0 || ph == 1) begin
					wave_backlog.push_back(wave_t'(edges[k]));
				end
			end
			for (n = 0; n < RAND_ITEMS; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					wave_backlog.push_back(wave_t'($urandom_range(0, 1023)));
				end else begin
					wave_backlog.push_back(wave_t'($urandom_range(380, 780)));
				end
			end
		end
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("wavelength_to_rgb: match");
		end else begin
			$display("wavelength_to_rgb: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("wavelength_to_rgb: mismatch");
		$finish;
	end

endmodule
